// ----- sv/dense_graph_shortest_path_macros.svh -----
// ----------------------------------------------------------------------------
// Dense graph shortest path: assertion macros
// Shared assertion forms for the checker, all clocked on clock and quiet in
// reset.
// ----------------------------------------------------------------------------
`ifndef DENSE_GRAPH_SHORTEST_PATH_MACROS_SVH
`define DENSE_GRAPH_SHORTEST_PATH_MACROS_SVH

`define DGSP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`define DGSP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/dgsp_pkg.sv -----
// ----------------------------------------------------------------------------
// Dense graph shortest path: package
// Field widths, command codes and the shared adder and comparator types.
// ----------------------------------------------------------------------------
package dgsp_pkg;

   localparam int NODE_W   = 6;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 22;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic [DIST_W-1:0]   a;
      logic [WEIGHT_W-1:0] b;
      logic [DIST_W-1:0]   c;
   } alu_req_type;

   typedef struct packed {
      logic [DIST_W-1:0] sum;
      logic              lt;
   } alu_rsp_type;

endpackage

// ----- sv/dgsp_ram.sv -----
// ----------------------------------------------------------------------------
// Dense graph shortest path: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dgsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- sv/dgsp_alu.sv -----
// ----------------------------------------------------------------------------
// Dense graph shortest path: shared adder and comparator
// Adds an edge weight to a distance and compares the sum with a second one.
// ----------------------------------------------------------------------------
module dgsp_alu
   import dgsp_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   always_comb begin
      rsp.sum = req.a + DIST_W'(req.b);
      rsp.lt  = rsp.sum < req.c;
   end

endmodule

// ----- sv/dense_graph_shortest_path.sv -----
// ----------------------------------------------------------------------------
// Dense graph shortest path: top level
// Adjacency matrix store with a sequenced shortest path search.
//
// Channel   Ports          Transfer
// request   start, req_*   start high while busy is low
// result    rsp_*          rsp_valid high for one cycle, no stall
//
// A write, a clear request or cmd 3 is taken while idle; a clear then
// sweeps all NODES*NODES edge entries, as does the sweep after reset.
// A query is sequenced through the single read port of the node store and
// the one shared adder. Results leave one a cycle and cannot be held off.
// ----------------------------------------------------------------------------
module dense_graph_shortest_path
   import dgsp_pkg::*;
#(
   parameter int NODES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_cmd,
   input  logic [NODE_W-1:0]   req_from_node,
   input  logic [NODE_W-1:0]   req_to_node,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic                req_edge_present,
   output logic                rsp_valid,
   output logic [NODE_W-1:0]   rsp_path_node,
   output logic [DIST_W-1:0]   rsp_total_distance,
   output logic                rsp_reachable,
   output logic                rsp_last
);

   localparam int NW  = $clog2(NODES);
   localparam int EAW = $clog2(NODES * NODES);
   localparam int EDW = WEIGHT_W + 1;
   localparam int NDW = DIST_W + NW + 3;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_INIT, ST_SCAN, ST_MARK, ST_RELAX,
      ST_FINAL, ST_FINAL_WAIT, ST_WALK_RD, ST_WALK, ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [NW:0]         cnt_ff, cnt_in, cnt_dec;
   logic                pv_ff, pv_in;
   logic [NW-1:0]       pidx_ff, pidx_in;
   logic [NW-1:0]       round_ff, round_in;
   logic [NW-1:0]       start_ff, start_in, end_ff, end_in;
   logic                found_ff, found_in;
   logic [DIST_W-1:0]   best_ff, best_in;
   logic [NW-1:0]       u_ff, u_in;
   logic [NDW-1:0]      uword_ff, uword_in;
   logic [NW:0]         len_ff, len_in, len_inc;
   logic [NW-1:0]       walk_ff, walk_in;
   logic [DIST_W-1:0]   total_ff, total_in;
   logic [EAW-1:0]      clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]   rsp_node_ff, rsp_node_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic                rsp_reach_ff, rsp_reach_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                e_wr_en;
   logic [EAW-1:0]      e_wr_addr, e_rd_addr;
   logic [EDW-1:0]      e_wr_data, e_rd_data;
   logic                n_wr_en;
   logic [NW-1:0]       n_wr_addr, n_rd_addr;
   logic [NDW-1:0]      n_wr_data, n_rd_data;
   logic                p_wr_en;
   logic [NW-1:0]       p_wr_addr, p_rd_addr;
   logic [NW-1:0]       p_wr_data, p_rd_data;

   logic                nr_vis, nr_hasp, nr_reached;
   logic [NW-1:0]       nr_parent;
   logic [DIST_W-1:0]   nr_dist;
   logic                from_ok, to_ok;
   alu_req_type         alu_req;
   alu_rsp_type         alu_rsp;

   dgsp_ram #(.WIDTH(EDW), .DEPTH(NODES * NODES)) u_edge_ram (
      .clock(clock), .wr_en(e_wr_en), .wr_addr(e_wr_addr), .wr_data(e_wr_data),
      .rd_addr(e_rd_addr), .rd_data(e_rd_data)
   );

   dgsp_ram #(.WIDTH(NDW), .DEPTH(NODES)) u_node_ram (
      .clock(clock), .wr_en(n_wr_en), .wr_addr(n_wr_addr), .wr_data(n_wr_data),
      .rd_addr(n_rd_addr), .rd_data(n_rd_data)
   );

   dgsp_ram #(.WIDTH(NW), .DEPTH(NODES)) u_path_ram (
      .clock(clock), .wr_en(p_wr_en), .wr_addr(p_wr_addr), .wr_data(p_wr_data),
      .rd_addr(p_rd_addr), .rd_data(p_rd_data)
   );

   dgsp_alu u_alu (.req(alu_req), .rsp(alu_rsp));

   assign nr_vis     = n_rd_data[NDW-1];
   assign nr_hasp    = n_rd_data[NDW-2];
   assign nr_reached = n_rd_data[NDW-3];
   assign nr_parent  = n_rd_data[DIST_W +: NW];
   assign nr_dist    = n_rd_data[DIST_W-1:0];
   assign from_ok    = {1'b0, req_from_node} < 7'(NODES);
   assign to_ok      = {1'b0, req_to_node} < 7'(NODES);
   assign cnt_dec    = cnt_ff - 1'b1;
   assign len_inc    = len_ff + 1'b1;

   always_comb begin
      if (state_ff == ST_SCAN) begin
         alu_req.a = nr_dist;
         alu_req.b = '0;
         alu_req.c = best_ff;
      end else begin
         alu_req.a = best_ff;
         alu_req.b = e_rd_data[WEIGHT_W-1:0];
         alu_req.c = nr_dist;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pv_in        = 1'b0;
      pidx_in      = pidx_ff;
      round_in     = round_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      u_in         = u_ff;
      uword_in     = uword_ff;
      len_in       = len_ff;
      walk_in      = walk_ff;
      total_in     = total_ff;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_node_in  = rsp_node_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_reach_in = rsp_reach_ff;
      rsp_last_in  = rsp_last_ff;
      e_wr_en      = 1'b0;
      e_wr_addr    = clr_ff;
      e_wr_data    = '0;
      e_rd_addr    = EAW'(u_ff) * EAW'(NODES) + EAW'(cnt_ff[NW-1:0]);
      n_wr_en      = 1'b0;
      n_wr_addr    = pidx_ff;
      n_wr_data    = {3'b011, u_ff, alu_rsp.sum};
      n_rd_addr    = cnt_ff[NW-1:0];
      p_wr_en      = 1'b0;
      p_wr_addr    = len_ff[NW-1:0];
      p_wr_data    = walk_ff;
      p_rd_addr    = cnt_dec[NW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            e_wr_en = 1'b1;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == EAW'(NODES * NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            e_wr_addr = EAW'(req_from_node[NW-1:0]) * EAW'(NODES)
                        + EAW'(req_to_node[NW-1:0]);
            e_wr_data = req_edge_present ? {1'b1, req_weight} : '0;
            if (start) begin
               priority case (req_cmd)
                  CMD_WRITE: begin
                     e_wr_en = from_ok && to_ok;
                  end
                  CMD_QUERY: begin
                     start_in = req_from_node[NW-1:0];
                     end_in   = req_to_node[NW-1:0];
                     cnt_in   = '0;
                     if (from_ok && to_ok) begin
                        state_in = ST_INIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_node_in  = '0;
                        rsp_dist_in  = '0;
                        rsp_reach_in = 1'b0;
                        rsp_last_in  = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            n_wr_en   = 1'b1;
            n_wr_addr = cnt_ff[NW-1:0];
            n_wr_data = {2'b00, cnt_ff[NW-1:0] == start_ff, {NW{1'b0}}, {DIST_W{1'b0}}};
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == (NW+1)'(NODES - 1)) begin
               cnt_in   = '0;
               round_in = '0;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff < (NW+1)'(NODES)) begin
               pv_in   = 1'b1;
               pidx_in = cnt_ff[NW-1:0];
               cnt_in  = cnt_ff + 1'b1;
            end
            if (pv_ff && !nr_vis && nr_reached && (!found_ff || alu_rsp.lt)) begin
               found_in = 1'b1;
               best_in  = nr_dist;
               u_in     = pidx_ff;
               uword_in = n_rd_data;
            end
            if (cnt_ff == (NW+1)'(NODES) && !pv_ff) begin
               state_in = found_ff ? ST_MARK : ST_FINAL;
            end
         end
         ST_MARK: begin
            n_wr_en   = 1'b1;
            n_wr_addr = u_ff;
            n_wr_data = {1'b1, uword_ff[NDW-2:0]};
            cnt_in    = '0;
            state_in  = ST_RELAX;
         end
         ST_RELAX: begin
            if (cnt_ff < (NW+1)'(NODES)) begin
               pv_in   = 1'b1;
               pidx_in = cnt_ff[NW-1:0];
               cnt_in  = cnt_ff + 1'b1;
            end
            n_wr_en = pv_ff && !nr_vis && e_rd_data[EDW-1] && (!nr_reached || alu_rsp.lt);
            if (cnt_ff == (NW+1)'(NODES) && !pv_ff) begin
               cnt_in   = '0;
               found_in = 1'b0;
               if (round_ff == NW'(NODES - 2)) begin
                  state_in = ST_FINAL;
               end else begin
                  round_in = round_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_FINAL: begin
            n_rd_addr = end_ff;
            state_in  = ST_FINAL_WAIT;
         end
         ST_FINAL_WAIT: begin
            if (!nr_reached) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = '0;
               rsp_dist_in  = '0;
               rsp_reach_in = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               total_in = nr_dist;
               len_in   = '0;
               walk_in  = end_ff;
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            n_rd_addr = walk_ff;
            state_in  = ST_WALK;
         end
         ST_WALK: begin
            p_wr_en = 1'b1;
            len_in  = len_inc;
            if (!nr_hasp || len_inc == (NW+1)'(NODES)) begin
               cnt_in   = len_inc;
               state_in = ST_EMIT;
            end else begin
               walk_in  = nr_parent;
               state_in = ST_WALK_RD;
            end
         end
         ST_EMIT: begin
            if (cnt_ff != '0) begin
               pv_in   = 1'b1;
               pidx_in = cnt_dec[NW-1:0];
               cnt_in  = cnt_dec;
            end
            if (pv_ff) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = NODE_W'(p_rd_data);
               rsp_dist_in  = total_ff;
               rsp_reach_in = 1'b1;
               rsp_last_in  = pidx_ff == '0;
            end
            if (cnt_ff == '0 && !pv_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pidx_ff      <= pidx_in;
      round_ff     <= round_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      u_ff         <= u_in;
      uword_ff     <= uword_in;
      len_ff       <= len_in;
      walk_ff      <= walk_in;
      total_ff     <= total_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_reach_ff <= rsp_reach_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy               = state_ff != ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_path_node      = rsp_node_ff;
   assign rsp_total_distance = rsp_dist_ff;
   assign rsp_reachable      = rsp_reach_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// ----- sv/dgsp_checker.sv -----
// ----------------------------------------------------------------------------
// Dense graph shortest path: port checker
// Watches the top level's ports and checks results and busy over time.
// ----------------------------------------------------------------------------
`include "dense_graph_shortest_path_macros.svh"

module dgsp_checker
   import dgsp_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [1:0]          req_cmd,
   input logic                rsp_valid,
   input logic [NODE_W-1:0]   rsp_path_node,
   input logic [DIST_W-1:0]   rsp_total_distance,
   input logic                rsp_reachable,
   input logic                rsp_last
);

   `DGSP_ASSERT_SAME(a_unreach_last, rsp_valid && !rsp_reachable, rsp_last, "unreachable result not last")
   `DGSP_ASSERT_SAME(a_unreach_zero, rsp_valid && !rsp_reachable, rsp_total_distance == '0 && rsp_path_node == '0, "unreachable result not zero")
   `DGSP_ASSERT_NEXT(a_write_quiet, start && !busy && req_cmd == CMD_WRITE, !rsp_valid, "result after an edge write")
   `DGSP_ASSERT_NEXT(a_clear_busy, start && !busy && req_cmd == CMD_CLEAR, busy, "clear transfer without sweep")

endmodule

bind dense_graph_shortest_path dgsp_checker u_dgsp_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy), .req_cmd(req_cmd),
   .rsp_valid(rsp_valid), .rsp_path_node(rsp_path_node),
   .rsp_total_distance(rsp_total_distance), .rsp_reachable(rsp_reachable),
   .rsp_last(rsp_last)
);
